>>> sv/gpf_pkg.sv
// ----------------------------------------------------------------------------
// gpf_pkg
// Shared constants, state types and control structs of the priority-flood
// trapped volume block.
// ----------------------------------------------------------------------------
package gpf_pkg;

    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_MAX_COLS    = 64;
    localparam int DEF_HEIGHT_BITS = 16;
    localparam int DEF_HEAP_DEPTH  = 16384;

    localparam int MIN_SIDE       = 3;
    localparam int COUNT_BITS     = 7;
    localparam int IN_HEIGHT_BITS = 16;
    localparam int VOL_BITS       = 28;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT    = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_COUNT = 1'b1;

    localparam logic [COUNT_BITS-1:0] COUNT_RESET = 7'd64;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SEED,
        S_SEED_NEXT,
        S_REACH_RD,
        S_REACH_CHK,
        S_POP,
        S_POP_WAIT,
        S_BASE,
        S_NBR,
        S_DONE
    } flood_state_t;

    typedef enum logic [2:0] {
        H_IDLE,
        H_UP_CMP,
        H_UP_FIN,
        H_DN_TOP,
        H_DN_LAST,
        H_DN_STEP,
        H_DN_C,
        H_DN_C1
    } heap_state_t;

    typedef struct packed {
        logic push;
        logic pop;
    } heap_ctl_t;

    typedef struct packed {
        logic busy;
        logic empty;
    } heap_stat_t;

endpackage

>>> sv/gpf_ram.sv
// ----------------------------------------------------------------------------
// gpf_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module gpf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/gpf_heap.sv
// ----------------------------------------------------------------------------
// gpf_heap
// Binary min-heap kept in one RAM, with sequential sift-up on push and
// sift-down on pop, ordered by the level field in the upper entry bits.
// ----------------------------------------------------------------------------
module gpf_heap #(
    parameter int ENTRY_BITS = 28,
    parameter int LEVEL_BITS = 16,
    parameter int DEPTH      = 16384
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  gpf_pkg::heap_ctl_t     ctl,
    input  logic [ENTRY_BITS-1:0]  push_entry,
    output gpf_pkg::heap_stat_t    stat,
    output logic [ENTRY_BITS-1:0]  top_entry
);

    localparam int HI = $clog2(DEPTH);
    localparam int SB = HI + 1;

    gpf_pkg::heap_state_t state_reg, state_next;
    logic [SB-1:0]         size_reg, size_next;
    logic [HI-1:0]         k_reg, k_next;
    logic [HI-1:0]         cidx_reg, cidx_next;
    logic [ENTRY_BITS-1:0] ent_reg, ent_next;
    logic [ENTRY_BITS-1:0] top_reg, top_next;
    logic [ENTRY_BITS-1:0] child_reg, child_next;

    logic                  rd_en, wr_en;
    logic [HI-1:0]         rd_addr, wr_addr;
    logic [ENTRY_BITS-1:0] wr_data, rd_data;

    logic [HI-1:0]         par_of_size, par_of_k, par_of_par;
    logic [SB-1:0]         c_idx, c1_idx;
    logic [ENTRY_BITS-1:0] best;
    logic [HI-1:0]         best_idx;
    logic                  rd_le_ent, best_ge_ent;

    gpf_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_heap_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign par_of_size = HI'((size_reg - SB'(1)) >> 1);
    assign par_of_k    = HI'((k_reg - HI'(1)) >> 1);
    assign par_of_par  = HI'((par_of_k - HI'(1)) >> 1);
    assign c_idx       = {k_reg, 1'b1};
    assign c1_idx      = SB'(cidx_reg) + SB'(1);
    assign rd_le_ent   = rd_data[ENTRY_BITS-1 -: LEVEL_BITS] <= ent_reg[ENTRY_BITS-1 -: LEVEL_BITS];

    always_comb
    begin
        best     = rd_data;
        best_idx = cidx_reg;
        if (state_reg == gpf_pkg::H_DN_C1)
        begin
            if (rd_data[ENTRY_BITS-1 -: LEVEL_BITS] < child_reg[ENTRY_BITS-1 -: LEVEL_BITS])
            begin
                best     = rd_data;
                best_idx = HI'(c1_idx);
            end
            else
            begin
                best     = child_reg;
                best_idx = cidx_reg;
            end
        end
    end

    assign best_ge_ent = best[ENTRY_BITS-1 -: LEVEL_BITS] >= ent_reg[ENTRY_BITS-1 -: LEVEL_BITS];

    // Next state and register updates.
    always_comb
    begin
        state_next = state_reg;
        size_next  = size_reg;
        k_next     = k_reg;
        cidx_next  = cidx_reg;
        ent_next   = ent_reg;
        top_next   = top_reg;
        child_next = child_reg;
        unique case (state_reg)
            gpf_pkg::H_IDLE:
            begin
                if (ctl.push)
                begin
                    if (size_reg != SB'(DEPTH))
                    begin
                        size_next = size_reg + SB'(1);
                        if (size_reg != '0)
                        begin
                            k_next     = HI'(size_reg);
                            ent_next   = push_entry;
                            state_next = gpf_pkg::H_UP_CMP;
                        end
                    end
                end
                else if (ctl.pop)
                begin
                    size_next  = size_reg - SB'(1);
                    state_next = gpf_pkg::H_DN_TOP;
                end
            end
            gpf_pkg::H_UP_CMP:
            begin
                if (rd_le_ent)
                begin
                    state_next = gpf_pkg::H_IDLE;
                end
                else
                begin
                    k_next = par_of_k;
                    if (par_of_k == '0)
                    begin
                        state_next = gpf_pkg::H_UP_FIN;
                    end
                end
            end
            gpf_pkg::H_UP_FIN:
            begin
                state_next = gpf_pkg::H_IDLE;
            end
            gpf_pkg::H_DN_TOP:
            begin
                top_next = rd_data;
                k_next   = '0;
                if (size_reg == '0)
                begin
                    state_next = gpf_pkg::H_IDLE;
                end
                else
                begin
                    state_next = gpf_pkg::H_DN_LAST;
                end
            end
            gpf_pkg::H_DN_LAST:
            begin
                ent_next   = rd_data;
                state_next = gpf_pkg::H_DN_STEP;
            end
            gpf_pkg::H_DN_STEP:
            begin
                if (c_idx >= size_reg)
                begin
                    state_next = gpf_pkg::H_IDLE;
                end
                else
                begin
                    cidx_next  = HI'(c_idx);
                    state_next = gpf_pkg::H_DN_C;
                end
            end
            gpf_pkg::H_DN_C, gpf_pkg::H_DN_C1:
            begin
                child_next = rd_data;
                if (state_reg == gpf_pkg::H_DN_C && c1_idx < size_reg)
                begin
                    state_next = gpf_pkg::H_DN_C1;
                end
                else if (best_ge_ent)
                begin
                    state_next = gpf_pkg::H_IDLE;
                end
                else
                begin
                    k_next     = best_idx;
                    state_next = gpf_pkg::H_DN_STEP;
                end
            end
            default:
            begin
                state_next = gpf_pkg::H_IDLE;
            end
        endcase
    end

    // Memory port control.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = k_reg;
        wr_data = ent_reg;
        unique case (state_reg)
            gpf_pkg::H_IDLE:
            begin
                if (ctl.push)
                begin
                    if (size_reg == '0)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        wr_data = push_entry;
                    end
                    else if (size_reg != SB'(DEPTH))
                    begin
                        rd_en   = 1'b1;
                        rd_addr = par_of_size;
                    end
                end
                else if (ctl.pop)
                begin
                    rd_en   = 1'b1;
                    rd_addr = '0;
                end
            end
            gpf_pkg::H_UP_CMP:
            begin
                wr_en = 1'b1;
                if (!rd_le_ent)
                begin
                    wr_data = rd_data;
                    if (par_of_k != '0)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = par_of_par;
                    end
                end
            end
            gpf_pkg::H_UP_FIN:
            begin
                wr_en = 1'b1;
            end
            gpf_pkg::H_DN_TOP:
            begin
                if (size_reg != '0)
                begin
                    rd_en   = 1'b1;
                    rd_addr = HI'(size_reg);
                end
            end
            gpf_pkg::H_DN_LAST:
            begin
            end
            gpf_pkg::H_DN_STEP:
            begin
                if (c_idx >= size_reg)
                begin
                    wr_en = 1'b1;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = HI'(c_idx);
                end
            end
            gpf_pkg::H_DN_C, gpf_pkg::H_DN_C1:
            begin
                if (state_reg == gpf_pkg::H_DN_C && c1_idx < size_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = HI'(c1_idx);
                end
                else
                begin
                    wr_en = 1'b1;
                    if (!best_ge_ent)
                    begin
                        wr_data = best;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gpf_pkg::H_IDLE;
            size_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        cidx_reg  <= cidx_next;
        ent_reg   <= ent_next;
        top_reg   <= top_next;
        child_reg <= child_next;
    end

    assign stat.busy  = state_reg != gpf_pkg::H_IDLE;
    assign stat.empty = size_reg == '0;
    assign top_entry  = top_reg;

    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        size_reg <= SB'(DEPTH))
        else $error("heap size beyond depth");

    a_pop_start: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == gpf_pkg::H_DN_TOP |-> $past(state_reg == gpf_pkg::H_IDLE && ctl.pop))
        else $error("sift-down entered without a pop");

    a_no_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy |-> !(ctl.push || ctl.pop))
        else $error("heap command while busy");

endmodule

>>> sv/grid_priority_flood_fill_volume.sv
// ----------------------------------------------------------------------------
// grid_priority_flood_fill_volume
// Loads a height grid and computes the trapped water volume by priority flood.
// ----------------------------------------------------------------------------
// Configure row_count (index 0) and column_count (index 1) through the cfg
// channel while the block is idle; cfg_ready is always high.
// Heights enter on the input channel in raster order, one item per cycle
// while loading. The item that completes the grid starts the flood, and the
// input channel stalls until the result has been placed in the output
// register. The flood scans the grid cell by cell and pushes each border
// cell, then pops cells from the lowest level upward and pushes each
// unreached neighbour; the heap RAM's single read and write port sets this
// pace. A grid with fewer than three rows or columns skips the flood and
// answers with a volume of zero.
// One result item follows each grid and is held while out_stall is high;
// the next grid may load meanwhile, but its last item waits for the output
// register to drain.
// Reset clears all control state and sets both counts to 64; the height RAM
// needs no clearing since every flood only touches cells loaded just before.
// ----------------------------------------------------------------------------
module grid_priority_flood_fill_volume #(
    parameter int MAX_ROWS    = gpf_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = gpf_pkg::DEF_MAX_COLS,
    parameter int HEIGHT_BITS = gpf_pkg::DEF_HEIGHT_BITS,
    parameter int HEAP_DEPTH  = gpf_pkg::DEF_HEAP_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [gpf_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [gpf_pkg::COUNT_BITS-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [gpf_pkg::IN_HEIGHT_BITS-1:0]    height,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [gpf_pkg::VOL_BITS-1:0]          trapped_volume
);

    localparam int HB    = HEIGHT_BITS;
    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int PB    = $clog2(CELLS);
    localparam int RB    = $clog2(MAX_ROWS);
    localparam int CB    = $clog2(MAX_COLS);
    localparam int RCB   = $clog2(MAX_ROWS + 1);
    localparam int CCB   = $clog2(MAX_COLS + 1);
    localparam int TB    = PB + 1;
    localparam int EW    = HB + RB + CB;
    localparam int VB    = gpf_pkg::VOL_BITS;
    localparam int SW    = ((HB > VB) ? HB : VB) + 1;

    gpf_pkg::flood_state_t state_reg, state_next, ret_reg, ret_next;

    logic [gpf_pkg::COUNT_BITS-1:0] row_count_reg, column_count_reg;
    logic [PB-1:0]  pos_reg, pos_next;
    logic [VB-1:0]  sum_reg, sum_next;
    logic           out_valid_reg, out_valid_next;
    logic [VB-1:0]  out_data_reg, out_data_next;
    logic [PB-1:0]  tgt_addr_reg, tgt_addr_next;
    logic [RB-1:0]  tgt_row_reg, tgt_row_next;
    logic [CB-1:0]  tgt_col_reg, tgt_col_next;
    logic [HB-1:0]  from_reg, from_next;
    logic [RB-1:0]  sr_reg, sr_next;
    logic [CB-1:0]  sc_reg, sc_next;
    logic [PB-1:0]  saddr_reg, saddr_next;
    logic [RB-1:0]  pr_reg, pr_next;
    logic [CB-1:0]  pc_reg, pc_next;
    logic [HB-1:0]  plevel_reg, plevel_next;
    logic [PB-1:0]  base_reg, base_next;
    logic [1:0]     nbr_reg, nbr_next;

    logic [RCB-1:0] rows_eff;
    logic [CCB-1:0] cols_eff;
    logic [TB-1:0]  total;
    logic           in_fire, is_last, small_grid, border, seed_end;

    logic           cell_wr_en, cell_rd_en;
    logic [PB-1:0]  cell_wr_addr;
    logic [HB:0]    cell_wr_data, cell_rd_data;
    logic [HB-1:0]  h_in, cell_h, reach_lv;
    logic           cell_fixed, reach_new;
    logic [SW-1:0]  sum_wide;

    logic           nbr_ok;
    logic [PB-1:0]  nbr_addr;
    logic [RB-1:0]  nbr_row;
    logic [CB-1:0]  nbr_col;

    gpf_pkg::heap_ctl_t  heap_ctl;
    gpf_pkg::heap_stat_t heap_stat;
    logic [EW-1:0]       heap_top, heap_push_entry;

    gpf_ram #(
        .WIDTH (HB + 1),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .clk     (clk),
        .wr_en   (cell_wr_en),
        .wr_addr (cell_wr_addr),
        .wr_data (cell_wr_data),
        .rd_en   (cell_rd_en),
        .rd_addr (tgt_addr_reg),
        .rd_data (cell_rd_data)
    );

    gpf_heap #(
        .ENTRY_BITS (EW),
        .LEVEL_BITS (HB),
        .DEPTH      (HEAP_DEPTH)
    ) u_heap (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (heap_ctl),
        .push_entry (heap_push_entry),
        .stat       (heap_stat),
        .top_entry  (heap_top)
    );

    assign rows_eff = (row_count_reg == '0) ? RCB'(1) :
                      ((32'(row_count_reg) > 32'(MAX_ROWS)) ? RCB'(MAX_ROWS) : RCB'(row_count_reg));
    assign cols_eff = (column_count_reg == '0) ? CCB'(1) :
                      ((32'(column_count_reg) > 32'(MAX_COLS)) ? CCB'(MAX_COLS) :
                       CCB'(column_count_reg));
    assign total      = TB'(TB'(rows_eff) * TB'(cols_eff));
    assign is_last    = (TB'(pos_reg) + TB'(1)) >= total;
    assign small_grid = (32'(rows_eff) < gpf_pkg::MIN_SIDE) || (32'(cols_eff) < gpf_pkg::MIN_SIDE);
    assign in_stall   = (state_reg != gpf_pkg::S_LOAD) || (is_last && out_valid_reg);
    assign in_fire    = in_valid && !in_stall;
    assign h_in       = HB'(height);

    assign border   = (sr_reg == '0) || (RCB'(sr_reg) == rows_eff - RCB'(1)) ||
                      (sc_reg == '0) || (CCB'(sc_reg) == cols_eff - CCB'(1));
    assign seed_end = (RCB'(sr_reg) == rows_eff - RCB'(1)) && (CCB'(sc_reg) == cols_eff - CCB'(1));

    assign cell_fixed = cell_rd_data[HB];
    assign cell_h     = cell_rd_data[HB-1:0];
    assign reach_lv   = (from_reg > cell_h) ? from_reg : cell_h;
    assign reach_new  = (state_reg == gpf_pkg::S_REACH_CHK) && !cell_fixed;
    assign sum_wide   = SW'(sum_reg) + SW'(reach_lv - cell_h);
    assign heap_push_entry = {reach_lv, tgt_row_reg, tgt_col_reg};

    always_comb
    begin
        nbr_ok   = 1'b0;
        nbr_addr = base_reg;
        nbr_row  = pr_reg;
        nbr_col  = pc_reg;
        unique case (nbr_reg)
            2'd0:
            begin
                nbr_ok   = pr_reg != '0;
                nbr_addr = base_reg - PB'(cols_eff);
                nbr_row  = pr_reg - RB'(1);
            end
            2'd1:
            begin
                nbr_ok   = (RCB'(pr_reg) + RCB'(1)) < rows_eff;
                nbr_addr = base_reg + PB'(cols_eff);
                nbr_row  = pr_reg + RB'(1);
            end
            2'd2:
            begin
                nbr_ok   = pc_reg != '0;
                nbr_addr = base_reg - PB'(1);
                nbr_col  = pc_reg - CB'(1);
            end
            default:
            begin
                nbr_ok   = (CCB'(pc_reg) + CCB'(1)) < cols_eff;
                nbr_addr = base_reg + PB'(1);
                nbr_col  = pc_reg + CB'(1);
            end
        endcase
    end

    // Next state and register updates.
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        tgt_addr_next  = tgt_addr_reg;
        tgt_row_next   = tgt_row_reg;
        tgt_col_next   = tgt_col_reg;
        from_next      = from_reg;
        sr_next        = sr_reg;
        sc_next        = sc_reg;
        saddr_next     = saddr_reg;
        pr_next        = pr_reg;
        pc_next        = pc_reg;
        plevel_next    = plevel_reg;
        base_next      = base_reg;
        nbr_next       = nbr_reg;
        unique case (state_reg)
            gpf_pkg::S_LOAD:
            begin
                if (in_fire)
                begin
                    if (is_last)
                    begin
                        pos_next   = '0;
                        sum_next   = '0;
                        sr_next    = '0;
                        sc_next    = '0;
                        saddr_next = '0;
                        state_next = small_grid ? gpf_pkg::S_DONE : gpf_pkg::S_SEED;
                    end
                    else
                    begin
                        pos_next = pos_reg + PB'(1);
                    end
                end
            end
            gpf_pkg::S_SEED:
            begin
                if (!border)
                begin
                    state_next = gpf_pkg::S_SEED_NEXT;
                end
                else if (!heap_stat.busy)
                begin
                    tgt_addr_next = saddr_reg;
                    tgt_row_next  = sr_reg;
                    tgt_col_next  = sc_reg;
                    from_next     = '0;
                    ret_next      = gpf_pkg::S_SEED_NEXT;
                    state_next    = gpf_pkg::S_REACH_RD;
                end
            end
            gpf_pkg::S_SEED_NEXT:
            begin
                saddr_next = saddr_reg + PB'(1);
                if (CCB'(sc_reg) == cols_eff - CCB'(1))
                begin
                    sc_next = '0;
                    sr_next = sr_reg + RB'(1);
                end
                else
                begin
                    sc_next = sc_reg + CB'(1);
                end
                state_next = seed_end ? gpf_pkg::S_POP : gpf_pkg::S_SEED;
            end
            gpf_pkg::S_REACH_RD:
            begin
                state_next = gpf_pkg::S_REACH_CHK;
            end
            gpf_pkg::S_REACH_CHK:
            begin
                if (!cell_fixed)
                begin
                    sum_next = (sum_wide > SW'({VB{1'b1}})) ? {VB{1'b1}} : VB'(sum_wide);
                end
                state_next = ret_reg;
            end
            gpf_pkg::S_POP:
            begin
                if (!heap_stat.busy)
                begin
                    state_next = heap_stat.empty ? gpf_pkg::S_DONE : gpf_pkg::S_POP_WAIT;
                end
            end
            gpf_pkg::S_POP_WAIT:
            begin
                if (!heap_stat.busy)
                begin
                    plevel_next = heap_top[EW-1 -: HB];
                    pr_next     = heap_top[CB +: RB];
                    pc_next     = heap_top[CB-1:0];
                    state_next  = gpf_pkg::S_BASE;
                end
            end
            gpf_pkg::S_BASE:
            begin
                base_next  = PB'(PB'(pr_reg) * PB'(cols_eff)) + PB'(pc_reg);
                nbr_next   = '0;
                state_next = gpf_pkg::S_NBR;
            end
            gpf_pkg::S_NBR:
            begin
                if (!heap_stat.busy)
                begin
                    nbr_next = nbr_reg + 2'd1;
                    ret_next = (nbr_reg == 2'd3) ? gpf_pkg::S_POP : gpf_pkg::S_NBR;
                    if (nbr_ok)
                    begin
                        tgt_addr_next = nbr_addr;
                        tgt_row_next  = nbr_row;
                        tgt_col_next  = nbr_col;
                        from_next     = plevel_reg;
                        state_next    = gpf_pkg::S_REACH_RD;
                    end
                    else
                    begin
                        state_next = (nbr_reg == 2'd3) ? gpf_pkg::S_POP : gpf_pkg::S_NBR;
                    end
                end
            end
            gpf_pkg::S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = sum_reg;
                    state_next     = gpf_pkg::S_LOAD;
                end
            end
            default:
            begin
                state_next = gpf_pkg::S_LOAD;
            end
        endcase
    end

    // Memory and heap control.
    always_comb
    begin
        cell_wr_en   = 1'b0;
        cell_wr_addr = tgt_addr_reg;
        cell_wr_data = {1'b1, cell_h};
        cell_rd_en   = state_reg == gpf_pkg::S_REACH_RD;
        heap_ctl     = '0;
        if (in_fire)
        begin
            cell_wr_en   = 1'b1;
            cell_wr_addr = pos_reg;
            cell_wr_data = {1'b0, h_in};
        end
        else if (reach_new)
        begin
            cell_wr_en = 1'b1;
        end
        heap_ctl.push = reach_new;
        heap_ctl.pop  = (state_reg == gpf_pkg::S_POP) && !heap_stat.busy && !heap_stat.empty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= gpf_pkg::S_LOAD;
            ret_reg          <= gpf_pkg::S_POP;
            pos_reg          <= '0;
            sum_reg          <= '0;
            out_valid_reg    <= 1'b0;
            nbr_reg          <= '0;
            row_count_reg    <= gpf_pkg::COUNT_RESET;
            column_count_reg <= gpf_pkg::COUNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            nbr_reg       <= nbr_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    gpf_pkg::REG_ROW_COUNT:    row_count_reg    <= cfg_data;
                    gpf_pkg::REG_COLUMN_COUNT: column_count_reg <= cfg_data;
                    default:                   row_count_reg    <= row_count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        tgt_addr_reg <= tgt_addr_next;
        tgt_row_reg  <= tgt_row_next;
        tgt_col_reg  <= tgt_col_next;
        from_reg     <= from_next;
        sr_reg       <= sr_next;
        sc_reg       <= sc_next;
        saddr_reg    <= saddr_next;
        pr_reg       <= pr_next;
        pc_reg       <= pc_next;
        plevel_reg   <= plevel_next;
        base_reg     <= base_next;
    end

    assign cfg_ready      = 1'b1;
    assign out_valid      = out_valid_reg;
    assign trapped_volume = out_data_reg;

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == gpf_pkg::S_DONE))
        else $error("result raised outside the done state");

    a_reach_heap_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == gpf_pkg::S_REACH_CHK |-> !heap_stat.busy)
        else $error("cell reached while heap busy");

    a_done_heap_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == gpf_pkg::S_DONE && !small_grid |-> heap_stat.empty && !heap_stat.busy)
        else $error("flood finished with heap work pending");

endmodule
